// ===== rtl/core/ias_pkg.sv =====
// Shared types and constants for the icon animation sequencer.
package ias_pkg;

  // Command codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_TICK  = 2'd2
  } ias_func_t;

  // Sequencer control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_CUR,
    ST_EXEC
  } ias_state_t;

  localparam logic [15:0] WORD_STATIC   = 16'h0100;
  localparam logic [15:0] WORD_END      = 16'h0000;
  localparam logic [15:0] DURATION_MASK = 16'h00FF;

  typedef struct packed {
    logic [1:0]  func;
    logic        slot;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
  } ias_in_t;

  typedef struct packed {
    logic       update_icon;
    logic [2:0] palette_index;
    logic [2:0] bitmap_index;
    logic       flip_horizontal;
    logic       flip_vertical;
  } ias_out_t;

  // Port enables for the sequence memory.
  typedef struct packed {
    logic wr;
    logic clr;
    logic rd;
  } ias_ram_ctl_t;

endpackage

// ===== rtl/core/ias_seq_ram.sv =====
// Sequence word memory with per-entry valid bits for reset and slot clear.
module ias_seq_ram #(
  parameter int SLOT_COUNT = 2,
  parameter int SEQ_LENGTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ias_pkg::ias_ram_ctl_t        ctl,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_slot,
  input  logic [$clog2(SEQ_LENGTH)-1:0] wr_pos,
  input  logic [15:0]                  wr_data,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_slot,
  input  logic [$clog2(SEQ_LENGTH)-1:0] rd_pos,
  output logic [15:0]                  rd_data
);
  import ias_pkg::*;

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW    = $clog2(SEQ_LENGTH);
  localparam int DEPTH = 1 << (SW + PW);

  logic [15:0] mem [DEPTH];
  logic [SLOT_COUNT-1:0][SEQ_LENGTH-1:0] vld;
  logic [15:0] rd_raw;
  logic        rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[{wr_slot, wr_pos}] <= wr_data;
    end
    if (ctl.rd) begin
      rd_raw <= mem[{rd_slot, rd_pos}];
    end
  end

  // An entry never written since reset or the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.rd) begin
        rd_vld <= vld[rd_slot][rd_pos];
      end
      if (ctl.clr) begin
        vld[wr_slot] <= '0;
      end else if (ctl.wr) begin
        vld[wr_slot][wr_pos] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : WORD_END;

endmodule

// ===== rtl/core/icon_animation_sequencer_top.sv =====
// Top level of the icon animation sequencer: command decode, tick sequencing and slot state.
//
// Loads, clears and commands that do nothing are accepted in any cycle busy is low and
// return their all-zero result on done in the cycle after acceptance. A tick reads two sequence words,
// the next one and then the current one, through the single read port of the sequence
// memory: busy is high in the cycle after the tick is accepted (ST_READ_CUR), the result
// appears on done in ST_EXEC, which follows ST_READ_CUR, and a new command is accepted in
// that same result cycle, so a new tick is taken only once the last one has left ST_READ_CUR.
// Reset clears the tables at once. Every result is shown for exactly one cycle and cannot be held off.
module icon_animation_sequencer_top #(
  parameter int SLOT_COUNT = 2,
  parameter int SEQ_LENGTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ias_pkg::ias_in_t  cmd,
  output logic              done,
  output ias_pkg::ias_out_t result
);
  import ias_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW = $clog2(SEQ_LENGTH);

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    next_pos = (p == PW'(SEQ_LENGTH - 1)) ? '0 : p + 1'b1;
  endfunction

  ias_state_t state, state_next;

  logic [SW-1:0] op_slot;
  logic          simple_done;
  logic [15:0]   next_word;

  logic [PW-1:0] pos       [SLOT_COUNT];
  logic [7:0]    dly       [SLOT_COUNT];
  logic [2:0]    last_pal  [SLOT_COUNT];
  logic [2:0]    last_bmp  [SLOT_COUNT];
  logic [1:0]    last_flip [SLOT_COUNT];

  logic          accept;
  logic          slot_ok;
  logic          is_tick;
  logic [SW-1:0] s_in;

  ias_ram_ctl_t  ram_ctl;
  logic [SW-1:0] rd_slot;
  logic [PW-1:0] rd_pos;
  logic [15:0]   ram_rd_data;
  logic [15:0]   cur_word;

  logic          is_static;
  logic [2:0]    pal, bmp;
  logic [1:0]    flip;
  logic [7:0]    dur, dly_inc, dly_new;
  logic          upd, adv, commit;
  logic [PW-1:0] pos_new, pos_fw;
  ias_out_t      tick_out;

  assign busy    = (state == ST_READ_CUR);
  assign accept  = start && !busy;
  assign slot_ok = int'(cmd.slot) < SLOT_COUNT;
  assign s_in    = SW'(cmd.slot);
  assign is_tick = (cmd.func == FUNC_TICK);

  // Tick evaluation, valid in ST_EXEC with the current word on the memory output.
  assign cur_word  = ram_rd_data;
  assign is_static = (next_word == WORD_STATIC);
  assign bmp       = cur_word[10:8];
  assign pal       = cur_word[13:11];
  assign flip      = cur_word[15:14];
  assign dur       = 8'(cur_word & DURATION_MASK);
  assign upd       = (pal != last_pal[op_slot]) || (bmp != last_bmp[op_slot]) ||
                     (flip != last_flip[op_slot]);
  assign dly_inc   = dly[op_slot] + 8'd1;
  assign adv       = (dly_inc >= dur);
  assign dly_new   = adv ? 8'd0 : dly_inc;
  assign commit    = (state == ST_EXEC) && !is_static;

  // The word after the current one is landed on when advancing, unless it is the end word, which wraps to zero.
  always_comb begin
    pos_new = pos[op_slot];
    if (adv) begin
      pos_new = (next_word == WORD_END) ? '0 : next_pos(pos[op_slot]);
    end
  end

  always_comb begin
    tick_out = '0;
    if (!is_static) begin
      tick_out.update_icon     = upd;
      tick_out.palette_index   = pal;
      tick_out.bitmap_index    = bmp;
      tick_out.flip_horizontal = flip[0];
      tick_out.flip_vertical   = flip[1];
    end
  end

  // A tick accepted while the previous one finishes sees that tick's new position.
  assign pos_fw = (commit && (s_in == op_slot)) ? pos_new : pos[s_in];

  always_comb begin
    ram_ctl     = '0;
    ram_ctl.wr  = accept && slot_ok && (cmd.func == FUNC_LOAD) &&
                  (int'(cmd.entry_index) < SEQ_LENGTH);
    ram_ctl.clr = accept && slot_ok && (cmd.func == FUNC_CLEAR);
    if (state == ST_READ_CUR) begin
      ram_ctl.rd = 1'b1;
      rd_slot    = op_slot;
      rd_pos     = pos[op_slot];
    end else begin
      ram_ctl.rd = accept && slot_ok && is_tick;
      rd_slot    = s_in;
      rd_pos     = next_pos(pos_fw);
    end
  end

  ias_seq_ram #(
    .SLOT_COUNT(SLOT_COUNT),
    .SEQ_LENGTH(SEQ_LENGTH)
  ) u_seq_ram (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ram_ctl),
    .wr_slot (s_in),
    .wr_pos  (PW'(cmd.entry_index)),
    .wr_data (cmd.entry_value),
    .rd_slot (rd_slot),
    .rd_pos  (rd_pos),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_EXEC: begin
        state_next = (accept && slot_ok && is_tick) ? ST_READ_CUR : ST_IDLE;
      end
      ST_READ_CUR: begin
        state_next = ST_EXEC;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    done   = simple_done || (state == ST_EXEC);
    result = (state == ST_EXEC) ? tick_out : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      simple_done <= 1'b0;
      op_slot     <= '0;
    end else begin
      state       <= state_next;
      simple_done <= accept && !(slot_ok && is_tick);
      if (accept) begin
        op_slot <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ_CUR) begin
      next_word <= ram_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pos[i]       <= '0;
        dly[i]       <= '0;
        last_pal[i]  <= '0;
        last_bmp[i]  <= '0;
        last_flip[i] <= '0;
      end
    end else if (commit) begin
      pos[op_slot]       <= pos_new;
      dly[op_slot]       <= dly_new;
      last_pal[op_slot]  <= pal;
      last_bmp[op_slot]  <= bmp;
      last_flip[op_slot] <= flip;
    end
  end

endmodule

// ===== rtl/core/ias_check.sv =====
// Port-level checks for the icon animation sequencer and their binding to the top level.
module ias_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ias_pkg::ias_in_t  cmd,
  input logic              done,
  input ias_pkg::ias_out_t result
);
  import ias_pkg::*;

  // The sequencer is busy for exactly one cycle per tick.
  a_busy_short: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A tick's result follows its busy cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (rst) busy |=> done)
    else $error("tick result missing after busy cycle");

  // No result is shown while a tick is reading the table.
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !done)
    else $error("result shown while busy");

  // Loads and clears return an all-zero result in the next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && (cmd.func == FUNC_LOAD || cmd.func == FUNC_CLEAR))
      |=> (done && result == '0))
    else $error("load or clear result missing or nonzero");

  // Every result stems from an accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
      done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

endmodule

bind icon_animation_sequencer_top ias_check u_ias_check (.*);
